@@ src/rtss_pkg.sv @@
// ----------------------------------------------------------------------------
// rtss_pkg: shared types and constants for the record table
// Record layout, opcodes, status codes and the in/out words.
// ----------------------------------------------------------------------------
package rtss_pkg;

  localparam int unsigned TableDepth = 64;
  localparam int unsigned IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CntW       = $clog2(TableDepth + 1);

  localparam logic [2:0] OpInsert = 3'd0;
  localparam logic [2:0] OpDelete = 3'd1;
  localparam logic [2:0] OpFindNm = 3'd2;
  localparam logic [2:0] OpFindId = 3'd3;
  localparam logic [2:0] OpModify = 3'd4;
  localparam logic [2:0] OpDump   = 3'd5;

  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StNotFound = 2'd1;
  localparam logic [1:0] StDup      = 2'd2;
  localparam logic [1:0] StFull     = 2'd3;

  localparam logic [1:0] SelId    = 2'd0;
  localparam logic [1:0] SelPrice = 2'd1;
  localparam logic [1:0] SelTotal = 2'd2;

  typedef struct packed {
    logic [111:0]       id;
    logic [111:0]       name;
    logic signed [31:0] price;
    logic signed [31:0] total;
    logic signed [31:0] left;
  } rec_t;

  typedef struct packed {
    logic [2:0]         op;
    logic [47:0]        id_hi;
    logic [63:0]        id_lo;
    logic [47:0]        name_hi;
    logic [63:0]        name_lo;
    logic signed [31:0] price;
    logic signed [31:0] total_amount;
    logic signed [31:0] left_amount;
    logic [1:0]         field_sel;
  } in_word_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [47:0]        out_id_hi;
    logic [63:0]        out_id_lo;
    logic [47:0]        out_name_hi;
    logic [63:0]        out_name_lo;
    logic signed [31:0] out_price;
    logic signed [31:0] out_total;
    logic signed [31:0] out_left;
    logic               last;
  } out_word_t;

endpackage

@@ src/rtss_ram.sv @@
// ----------------------------------------------------------------------------
// rtss_ram: record memory
// One write port, one registered read port.
// ----------------------------------------------------------------------------
module rtss_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned AddrW = 6,
  parameter int unsigned DataW = 8
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ src/record_table_sort_search.sv @@
// ----------------------------------------------------------------------------
// record_table_sort_search: sorted record table with search
// Sequencer over one record memory and one 112-bit compare unit.
// ----------------------------------------------------------------------------
// One word is taken at a time; in_ready_o is low until every result of it has
// been delivered. The memory has one write port and one registered read port,
// and the search and sort steps read one record per cycle. Delete then shifts
// the later records down. Insert and dump run a full bubble sort over the
// stored records. A dump then streams the sorted records in order, each one
// held until out_ready_i is high.
// No clearing pass after reset.
module record_table_sort_search (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  rtss_pkg::in_word_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output rtss_pkg::out_word_t out_data_o
);

  localparam int unsigned IdxW = rtss_pkg::IdxW;
  localparam int unsigned CntW = rtss_pkg::CntW;
  localparam int unsigned RecW = $bits(rtss_pkg::rec_t);

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH, S_WRITE, S_PASS, S_LOAD, S_CMP, S_FLUSH, S_DEL_RD,
    S_DEL_WR, S_DUMP_RD, S_DUMP_WAIT, S_RESP
  } state_e;

  state_e              state_q;
  rtss_pkg::in_word_t  req_q;
  logic [CntW-1:0]     cnt_q;
  logic [IdxW:0]       ra_q;       // issued read address, one wider for end test
  logic [IdxW:0]       rb_q;       // address whose data appears now
  logic                rv_q;
  logic [IdxW-1:0]     j_q;
  logic [CntW-1:0]     lim_q;
  logic                dump_q;
  rtss_pkg::rec_t      a_q;        // record currently at position j of a pass
  rtss_pkg::out_word_t resp_q;
  logic                out_v_q;

  // memory ports
  logic              we;
  logic [IdxW-1:0]   waddr, raddr;
  rtss_pkg::rec_t    wdata, rdata;

  rtss_ram #(.Depth(rtss_pkg::TableDepth), .AddrW(IdxW), .DataW(RecW)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // shared 112-bit compare unit
  logic [111:0] cmp_a, cmp_b;
  logic         cmp_eq, cmp_ge;
  assign cmp_eq = (cmp_a == cmp_b);
  assign cmp_ge = (cmp_a >= cmp_b);

  logic [111:0] key_id, key_nm;
  logic         by_id;
  assign key_id = {req_q.id_hi, req_q.id_lo};
  assign key_nm = {req_q.name_hi, req_q.name_lo};
  assign by_id  = (req_q.op == rtss_pkg::OpInsert) || (req_q.op == rtss_pkg::OpFindId);

  always_comb begin
    cmp_a = by_id ? rdata.id : rdata.name;
    cmp_b = by_id ? key_id : key_nm;
    if (state_q == S_CMP) begin
      cmp_a = a_q.id;
      cmp_b = rdata.id;
    end
  end

  // rdata holds entry rb_q when rv_q is set
  logic hit;
  assign hit = rv_q && cmp_eq;

  function automatic rtss_pkg::out_word_t mk_out(logic [1:0] st, rtss_pkg::rec_t r,
                                                 logic use_rec, logic lst);
    rtss_pkg::out_word_t o;
    o = '0;
    o.status = st;
    o.last   = lst;
    if (use_rec) begin
      o.out_id_hi   = r.id[111:64];
      o.out_id_lo   = r.id[63:0];
      o.out_name_hi = r.name[111:64];
      o.out_name_lo = r.name[63:0];
      o.out_price   = r.price;
      o.out_total   = r.total;
      o.out_left    = r.left;
    end
    return o;
  endfunction

  rtss_pkg::rec_t mod_rec;
  always_comb begin
    mod_rec = rdata;
    case (req_q.field_sel)
      rtss_pkg::SelId:    mod_rec.id    = key_id;
      rtss_pkg::SelPrice: mod_rec.price = req_q.price;
      rtss_pkg::SelTotal: mod_rec.total = req_q.total_amount;
      default:            mod_rec.left  = req_q.left_amount;
    endcase
  end

  rtss_pkg::rec_t new_rec;
  assign new_rec = '{id: key_id, name: key_nm, price: req_q.price,
                     total: req_q.total_amount, left: req_q.left_amount};

  logic [IdxW:0] cnt_ext;
  assign cnt_ext = (IdxW + 1)'(cnt_q);

  // memory port control
  always_comb begin
    we    = 1'b0;
    waddr = j_q;
    wdata = a_q;
    raddr = ra_q[IdxW-1:0];
    case (state_q)
      S_SRCH: begin
        we    = (req_q.op == rtss_pkg::OpModify) && hit;
        waddr = rb_q[IdxW-1:0];
        wdata = mod_rec;
      end
      S_WRITE: begin
        we    = 1'b1;
        waddr = cnt_q[IdxW-1:0];
        wdata = new_rec;
      end
      S_PASS: raddr = '0;
      S_LOAD: raddr = IdxW'(1);
      // compare j with j+1, settle position j, fetch j+2
      S_CMP: begin
        we    = 1'b1;
        waddr = j_q;
        wdata = cmp_ge ? rdata : a_q;
        raddr = j_q + IdxW'(2);
      end
      S_FLUSH: begin
        we    = 1'b1;
        waddr = j_q + 1'b1;
        wdata = a_q;
      end
      S_DEL_WR: begin
        we    = 1'b1;
        waddr = ra_q[IdxW-1:0] - 1'b1;
        wdata = rdata;
      end
      default: ;
    endcase
  end

  logic full;
  assign full = (cnt_q == CntW'(rtss_pkg::TableDepth));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      req_q   <= '0;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
      resp_q  <= '0;
      rv_q    <= 1'b0;
      ra_q    <= '0;
      rb_q    <= '0;
      dump_q  <= 1'b0;
      a_q     <= '0;
      j_q     <= '0;
      lim_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q <= in_data_i;
            ra_q <= '0;
            rv_q <= 1'b0;
            case (in_data_i.op)
              rtss_pkg::OpInsert: begin
                if (full) begin
                  resp_q <= mk_out(rtss_pkg::StFull, '0, 1'b0, 1'b1);
                  out_v_q <= 1'b1;
                  state_q <= S_RESP;
                end else begin
                  state_q <= S_SRCH;
                end
              end
              rtss_pkg::OpDelete, rtss_pkg::OpFindNm, rtss_pkg::OpFindId,
              rtss_pkg::OpModify: state_q <= S_SRCH;
              rtss_pkg::OpDump: begin
                if (cnt_q == '0) begin
                  resp_q <= mk_out(rtss_pkg::StFull, '0, 1'b0, 1'b1);
                  out_v_q <= 1'b1;
                  state_q <= S_RESP;
                end else begin
                  dump_q <= 1'b1;
                  lim_q <= cnt_q;
                  state_q <= S_PASS;
                end
              end
              default: ;
            endcase
          end
        end
        // linear search: issue reads while below count, check the data in the next cycle
        S_SRCH: begin
          rv_q <= (ra_q < cnt_ext);
          rb_q <= ra_q;
          if (hit && req_q.op == rtss_pkg::OpDelete) ra_q <= rb_q + 1'b1;
          else if (ra_q < cnt_ext) ra_q <= ra_q + 1'b1;
          if (hit) begin
            case (req_q.op)
              rtss_pkg::OpInsert: begin
                resp_q <= mk_out(rtss_pkg::StDup, '0, 1'b0, 1'b1);
                out_v_q <= 1'b1;
                state_q <= S_RESP;
              end
              rtss_pkg::OpDelete: state_q <= S_DEL_RD;
              rtss_pkg::OpModify: begin
                resp_q <= mk_out(rtss_pkg::StOk, mod_rec, 1'b1, 1'b1);
                out_v_q <= 1'b1;
                state_q <= S_RESP;
              end
              default: begin
                resp_q <= mk_out(rtss_pkg::StOk, rdata, 1'b1, 1'b1);
                out_v_q <= 1'b1;
                state_q <= S_RESP;
              end
            endcase
          end else if (!rv_q && ra_q >= cnt_ext) begin
            if (req_q.op == rtss_pkg::OpInsert) begin
              state_q <= S_WRITE;
            end else begin
              resp_q <= mk_out(rtss_pkg::StNotFound, '0, 1'b0, 1'b1);
              out_v_q <= 1'b1;
              state_q <= S_RESP;
            end
          end
        end
        S_WRITE: begin
          cnt_q <= cnt_q + 1'b1;
          dump_q <= 1'b0;
          lim_q <= cnt_q + 1'b1;
          state_q <= S_PASS;
        end
        // bubble pass over entries 0..lim-1; a_q carries the record at j
        S_PASS: begin
          if (lim_q < CntW'(2)) begin
            if (dump_q) begin
              ra_q <= '0;
              state_q <= S_DUMP_RD;
            end else begin
              resp_q <= mk_out(rtss_pkg::StOk, '0, 1'b0, 1'b1);
              out_v_q <= 1'b1;
              state_q <= S_RESP;
            end
          end else begin
            state_q <= S_LOAD;
          end
        end
        S_LOAD: begin
          a_q <= rdata;
          j_q <= '0;
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (!cmp_ge) a_q <= rdata;
          if ((CntW'(j_q) + CntW'(2)) < lim_q) begin
            j_q <= j_q + 1'b1;
          end else begin
            state_q <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          lim_q <= lim_q - 1'b1;
          state_q <= S_PASS;
        end
        S_DEL_RD: begin
          if (ra_q >= cnt_ext) begin
            cnt_q <= cnt_q - 1'b1;
            resp_q <= mk_out(rtss_pkg::StOk, '0, 1'b0, 1'b1);
            out_v_q <= 1'b1;
            state_q <= S_RESP;
          end else begin
            state_q <= S_DEL_WR;
          end
        end
        S_DEL_WR: begin
          ra_q <= ra_q + 1'b1;
          state_q <= S_DEL_RD;
        end
        S_DUMP_RD: begin
          ra_q <= ra_q + 1'b1;
          rb_q <= ra_q;
          state_q <= S_DUMP_WAIT;
        end
        S_DUMP_WAIT: begin
          resp_q <= mk_out(rtss_pkg::StOk, rdata, 1'b1,
                           (rb_q + 1'b1) == cnt_ext);
          out_v_q <= 1'b1;
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (out_ready_i) begin
            out_v_q <= 1'b0;
            if (dump_q && !resp_q.last) begin
              state_q <= S_DUMP_RD;
            end else begin
              dump_q <= 1'b0;
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_v_q;
  assign out_data_o  = resp_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(rtss_pkg::TableDepth)) else $error("count overflow");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> state_q == S_RESP) else $error("result outside response state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_v_q) else $error("ready while result pending");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |=> cnt_q == $past(cnt_q) + 1'b1) else $error("insert count");

endmodule

@@ test/tb_record_table_sort_search.sv @@
// ----------------------------------------------------------------------------
// tb_record_table_sort_search: self-checking bench for the record table
// Directed and random insert/delete/find/modify/dump traffic against a local
// model of the table; results are checked word by word in order.
// ----------------------------------------------------------------------------
module tb_record_table_sort_search;

  localparam int unsigned Depth    = rtss_pkg::TableDepth;
  localparam int unsigned WdogMax  = 40000;
  localparam int unsigned NumRand  = 150;

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_ready_o;
  rtss_pkg::in_word_t  in_data_i;
  logic                out_valid_o;
  logic                out_ready_i;
  rtss_pkg::out_word_t out_data_o;

  record_table_sort_search uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // local copy of the table
  rtss_pkg::rec_t tbl [Depth];
  int unsigned    n_rec;

  rtss_pkg::in_word_t  pending_words[$];
  rtss_pkg::out_word_t expected_words[$];
  int unsigned n_fail;
  int unsigned n_sent;
  int unsigned n_drv;
  int unsigned n_got;
  int unsigned n_dumps;
  int unsigned idle_cnt;
  bit          quiet;
  bit          hold_done;
  int unsigned hold_cycles;
  int unsigned in_gap;
  int unsigned out_gap;

  // small id/name pools so that hits and duplicates are common
  logic [111:0] id_pool  [16];
  logic [111:0] name_pool[16];

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic rtss_pkg::out_word_t rec_word(logic [1:0] st, rtss_pkg::rec_t r,
                                                   logic lst);
    rtss_pkg::out_word_t w;
    w.status      = st;
    w.out_id_hi   = r.id[111:64];
    w.out_id_lo   = r.id[63:0];
    w.out_name_hi = r.name[111:64];
    w.out_name_lo = r.name[63:0];
    w.out_price   = r.price;
    w.out_total   = r.total;
    w.out_left    = r.left;
    w.last        = lst;
    return w;
  endfunction

  function automatic void sort_table();
    rtss_pkg::rec_t t;
    for (int i = 0; i < n_rec; i++)
      for (int j = 0; j + 1 + i < n_rec; j++)
        if (tbl[j].id >= tbl[j+1].id) begin
          t = tbl[j]; tbl[j] = tbl[j+1]; tbl[j+1] = t;
        end
  endfunction

  function automatic int find_name(logic [111:0] nm);
    for (int i = 0; i < n_rec; i++)
      if (tbl[i].name == nm) return i;
    return -1;
  endfunction

  function automatic int find_id(logic [111:0] id);
    for (int i = 0; i < n_rec; i++)
      if (tbl[i].id == id) return i;
    return -1;
  endfunction

  // apply one word to the local table and queue the words it produces
  function automatic void predict_table_op(rtss_pkg::in_word_t w);
    rtss_pkg::rec_t z;
    rtss_pkg::rec_t r;
    logic [111:0]   id;
    logic [111:0]   nm;
    int             k;
    z  = '0;
    id = {w.id_hi, w.id_lo};
    nm = {w.name_hi, w.name_lo};
    case (w.op)
      rtss_pkg::OpInsert: begin
        if (n_rec >= Depth)
          expected_words.push_back(rec_word(rtss_pkg::StFull, z, 1'b1));
        else if (find_id(id) >= 0)
          expected_words.push_back(rec_word(rtss_pkg::StDup, z, 1'b1));
        else begin
          r.id = id; r.name = nm; r.price = w.price;
          r.total = w.total_amount; r.left = w.left_amount;
          tbl[n_rec] = r;
          n_rec++;
          sort_table();
          expected_words.push_back(rec_word(rtss_pkg::StOk, z, 1'b1));
        end
      end
      rtss_pkg::OpDelete: begin
        k = find_name(nm);
        if (k < 0) expected_words.push_back(rec_word(rtss_pkg::StNotFound, z, 1'b1));
        else begin
          for (int i = k; i + 1 < n_rec; i++) tbl[i] = tbl[i+1];
          n_rec--;
          expected_words.push_back(rec_word(rtss_pkg::StOk, z, 1'b1));
        end
      end
      rtss_pkg::OpFindNm, rtss_pkg::OpFindId: begin
        k = (w.op == rtss_pkg::OpFindNm) ? find_name(nm) : find_id(id);
        if (k < 0) expected_words.push_back(rec_word(rtss_pkg::StNotFound, z, 1'b1));
        else expected_words.push_back(rec_word(rtss_pkg::StOk, tbl[k], 1'b1));
      end
      rtss_pkg::OpModify: begin
        k = find_name(nm);
        if (k < 0) expected_words.push_back(rec_word(rtss_pkg::StNotFound, z, 1'b1));
        else begin
          case (w.field_sel)
            rtss_pkg::SelId:    tbl[k].id    = id;
            rtss_pkg::SelPrice: tbl[k].price = w.price;
            rtss_pkg::SelTotal: tbl[k].total = w.total_amount;
            default:            tbl[k].left  = w.left_amount;
          endcase
          expected_words.push_back(rec_word(rtss_pkg::StOk, tbl[k], 1'b1));
        end
      end
      rtss_pkg::OpDump: begin
        if (n_rec == 0) expected_words.push_back(rec_word(rtss_pkg::StFull, z, 1'b1));
        else begin
          sort_table();
          for (int i = 0; i < n_rec; i++)
            expected_words.push_back(rec_word(rtss_pkg::StOk, tbl[i], i + 1 == n_rec));
        end
      end
      default: ;
    endcase
  endfunction

  function automatic logic [111:0] rand_text();
    return 112'({$urandom, $urandom, $urandom, $urandom});
  endfunction

  function automatic rtss_pkg::in_word_t make_word(logic [2:0] op, logic [111:0] id,
                                                   logic [111:0] nm, logic [1:0] sel);
    rtss_pkg::in_word_t w;
    w.op           = op;
    {w.id_hi, w.id_lo}     = id;
    {w.name_hi, w.name_lo} = nm;
    w.price        = $urandom;
    w.total_amount = $urandom;
    w.left_amount  = $urandom;
    w.field_sel    = sel;
    return w;
  endfunction

  function automatic rtss_pkg::in_word_t rand_word();
    logic [2:0]   op;
    logic [111:0] id;
    logic [111:0] nm;
    int unsigned  p;
    p = $urandom_range(99);
    if (p < 40)      op = rtss_pkg::OpInsert;
    else if (p < 52) op = rtss_pkg::OpDelete;
    else if (p < 64) op = rtss_pkg::OpFindNm;
    else if (p < 76) op = rtss_pkg::OpFindId;
    else if (p < 90) op = rtss_pkg::OpModify;
    else if (p < 95) op = rtss_pkg::OpDump;
    else             op = 3'($urandom_range(7));
    id = ($urandom_range(3) == 0) ? rand_text() : id_pool[$urandom_range(15)];
    nm = ($urandom_range(3) == 0) ? rand_text() : name_pool[$urandom_range(15)];
    return make_word(op, id, nm, 2'($urandom_range(3)));
  endfunction

  initial begin
    rtss_pkg::in_word_t w;
    for (int i = 0; i < 16; i++) begin
      id_pool[i]   = rand_text();
      name_pool[i] = rand_text();
    end
    id_pool[0] = '0;  id_pool[1] = '1;
    name_pool[0] = '0; name_pool[1] = '1;
    // empty-table cases
    pending_words.push_back(make_word(rtss_pkg::OpDump, '0, '0, rtss_pkg::SelId));
    pending_words.push_back(make_word(rtss_pkg::OpDelete, '0, name_pool[0], rtss_pkg::SelId));
    pending_words.push_back(make_word(rtss_pkg::OpFindNm, '0, name_pool[1], rtss_pkg::SelId));
    pending_words.push_back(make_word(rtss_pkg::OpFindId, '1, '0, rtss_pkg::SelId));
    pending_words.push_back(make_word(rtss_pkg::OpModify, '0, name_pool[0],
                                      rtss_pkg::SelPrice));
    // extremes, duplicate, finds, modify of every field, equal ids via modify
    pending_words.push_back(make_word(rtss_pkg::OpInsert, '1, name_pool[1], rtss_pkg::SelId));
    pending_words.push_back(make_word(rtss_pkg::OpInsert, '0, name_pool[0], rtss_pkg::SelId));
    pending_words.push_back(make_word(rtss_pkg::OpInsert, id_pool[2], name_pool[2],
                                      rtss_pkg::SelId));
    pending_words.push_back(make_word(rtss_pkg::OpInsert, '1, name_pool[3], rtss_pkg::SelId));
    pending_words.push_back(make_word(rtss_pkg::OpFindNm, '0, name_pool[2], rtss_pkg::SelId));
    pending_words.push_back(make_word(rtss_pkg::OpFindId, '1, '0, rtss_pkg::SelId));
    for (int s = 0; s < 4; s++)
      pending_words.push_back(make_word(rtss_pkg::OpModify, id_pool[4], name_pool[2], 2'(s)));
    pending_words.push_back(make_word(rtss_pkg::OpModify, '0, name_pool[1], rtss_pkg::SelId));
    pending_words.push_back(make_word(rtss_pkg::OpDump, '0, '0, rtss_pkg::SelId));
    pending_words.push_back(make_word(3'd6, '0, '0, rtss_pkg::SelId));
    pending_words.push_back(make_word(3'd7, '0, '0, rtss_pkg::SelId));
    pending_words.push_back(make_word(rtss_pkg::OpDelete, '0, name_pool[0], rtss_pkg::SelId));
    pending_words.push_back(make_word(rtss_pkg::OpDelete, '0, name_pool[5], rtss_pkg::SelId));
    pending_words.push_back(make_word(rtss_pkg::OpDump, '0, '0, rtss_pkg::SelId));
    for (int i = 0; i < NumRand; i++) pending_words.push_back(rand_word());
    // fill the table to capacity to reach the full status
    for (int i = 0; i < Depth + 2; i++) begin
      w = make_word(rtss_pkg::OpInsert, rand_text(), rand_text(), rtss_pkg::SelId);
      pending_words.push_back(w);
    end
    pending_words.push_back(make_word(rtss_pkg::OpDump, '0, '0, rtss_pkg::SelId));
    for (int i = 0; i < 20; i++) pending_words.push_back(rand_word());
  end

  // driver: a new word is offered only once n_sent catches up with n_drv
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      in_gap     <= 0;
      n_drv      <= 0;
    end else if (n_sent == n_drv) begin
      if (in_valid_i && !quiet && $urandom_range(5) == 0) begin
        in_valid_i <= 1'b0;
        in_gap     <= $urandom_range(12);
      end else if (in_gap > 0) begin
        in_valid_i <= 1'b0;
        in_gap     <= in_gap - 1;
      end else if (pending_words.size() > 0) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pending_words.pop_front();
        n_drv      <= n_drv + 1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // output side: random stalls, one long hold early in the run
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      out_gap     <= 0;
      hold_cycles <= 0;
      hold_done   <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (!hold_done && n_sent >= 8) begin
      out_ready_i <= 1'b0;
      hold_cycles <= 300;
      hold_done   <= 1'b1;
    end else if (out_gap > 0) begin
      out_ready_i <= 1'b0;
      out_gap     <= out_gap - 1;
    end else if (!quiet && $urandom_range(9) == 0) begin
      out_ready_i <= 1'b0;
      out_gap     <= $urandom_range(12);
    end else out_ready_i <= 1'b1;
  end

  // input handshake, predictor and watchdog at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_table_op(in_data_i);
        if (in_data_i.op == rtss_pkg::OpDump) n_dumps++;
        n_sent++;
        if (pending_words.size() < 40) quiet <= 1'b1;
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    rtss_pkg::out_word_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_got++;
      if (expected_words.size() == 0) begin
        n_fail++;
        $display("%0t: unexpected word %h", $time, out_data_o);
      end else begin
        e = expected_words.pop_front();
        if (out_data_o !== e) begin
          n_fail++;
          $display("%0t: mismatch expected %h actual %h", $time, e, out_data_o);
        end
      end
    end
  end

  initial begin
    n_rec = 0; n_fail = 0; n_sent = 0; n_got = 0; n_dumps = 0;
    idle_cnt = 0; quiet = 1'b0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    while (!(pending_words.size() == 0 && !in_valid_i && expected_words.size() == 0) &&
           idle_cnt < WdogMax)
      @(posedge clk_i);
    if (idle_cnt < WdogMax) repeat (50) @(posedge clk_i);
    if (idle_cnt >= WdogMax) begin
      $display("watchdog: no traffic, %0d words outstanding", expected_words.size());
      $display("Regression FAIL");
    end else begin
      if (expected_words.size() != 0) n_fail++;
      $display("Covered %0d input words (%0d dumps) and checked %0d result words.",
               n_sent, n_dumps, n_got);
      if (n_fail == 0) $display("Regression PASS");
      else $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/rtss_pkg.sv
src/rtss_ram.sv
src/record_table_sort_search.sv
test/tb_record_table_sort_search.sv
